// File: hdl/rgb_led_pattern_generator_unit_assert.svh
// Assertion macros for the RGB LED pattern generator.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef RGB_LED_PATTERN_GENERATOR_UNIT_ASSERT_SVH
`define RGB_LED_PATTERN_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLPG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rlpg_pkg.sv
// Package for the RGB LED pattern generator: item types, mode codes,
// color codes and the color lookup functions. No dependencies.
`timescale 1ns / 1ps

package rlpg_pkg;

	localparam int unsigned FADE_LIMIT = 5000;
	localparam int unsigned FADE_W = 13;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned INTERVAL_W = 16;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;
	localparam logic [FADE_W-1:0] FADE_PERIOD_RESET = 13'd500;

	localparam logic [3:0] MODE_RED = 4'd0;
	localparam logic [3:0] MODE_GREEN = 4'd1;
	localparam logic [3:0] MODE_BLUE = 4'd2;
	localparam logic [3:0] MODE_CYAN = 4'd3;
	localparam logic [3:0] MODE_MAGENTA = 4'd4;
	localparam logic [3:0] MODE_YELLOW = 4'd5;
	localparam logic [3:0] MODE_WHITE = 4'd6;
	localparam logic [3:0] MODE_FADE = 4'd7;
	localparam logic [3:0] MODE_HOLD = 4'd8;
	localparam logic [3:0] MODE_STROBE = 4'd9;
	localparam logic [3:0] MODE_RAINBOW = 4'd10;
	localparam logic [3:0] MODE_RED_BLUE = 4'd11;
	localparam logic [3:0] MODE_GREEN_RED = 4'd12;
	localparam logic [3:0] MODE_BLUE_GREEN = 4'd13;
	localparam logic [3:0] MODE_OFF_A = 4'd14;
	localparam logic [3:0] MODE_OFF_B = 4'd15;

	// Color codes: bit 0 red, bit 1 green, bit 2 blue, bit 3 means keep.
	localparam logic [3:0] C_OFF = 4'b0000;
	localparam logic [3:0] C_RED = 4'b0001;
	localparam logic [3:0] C_GREEN = 4'b0010;
	localparam logic [3:0] C_BLUE = 4'b0100;
	localparam logic [3:0] C_YELLOW = 4'b0011;
	localparam logic [3:0] C_CYAN = 4'b0110;
	localparam logic [3:0] C_MAGENTA = 4'b0101;
	localparam logic [3:0] C_WHITE = 4'b0111;
	localparam logic [3:0] C_KEEP = 4'b1000;

	typedef struct packed {
		logic [3:0] mode;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic red_on;
		logic green_on;
		logic blue_on;
	} out_item_t;

	function automatic logic [3:0] static_colour(input logic [2:0] idx);
		logic [3:0] c;
		case (idx)
			3'd0: c = C_RED;
			3'd1: c = C_GREEN;
			3'd2: c = C_BLUE;
			3'd3: c = C_CYAN;
			3'd4: c = C_MAGENTA;
			3'd5: c = C_YELLOW;
			3'd6: c = C_WHITE;
			default: c = C_KEEP;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] fade_colour(input logic [2:0] idx);
		logic [3:0] c;
		case (idx)
			3'd0: c = C_RED;
			3'd1: c = C_YELLOW;
			3'd2: c = C_GREEN;
			3'd3: c = C_CYAN;
			3'd4: c = C_BLUE;
			3'd5: c = C_MAGENTA;
			default: c = C_KEEP;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] rainbow_colour(input logic [2:0] idx);
		logic [3:0] c;
		case (idx)
			3'd0: c = C_RED;
			3'd1: c = C_GREEN;
			3'd2: c = C_BLUE;
			3'd3: c = C_CYAN;
			3'd4: c = C_YELLOW;
			3'd5: c = C_MAGENTA;
			default: c = C_KEEP;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] three_colour(input logic [1:0] idx);
		logic [3:0] c;
		case (idx)
			2'd0: c = C_RED;
			2'd1: c = C_GREEN;
			2'd2: c = C_BLUE;
			default: c = C_KEEP;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/rgb_led_pattern_generator_unit.sv
// Top level of the RGB LED pattern generator: input register, pattern logic,
// result register. Depends on rlpg_pkg and rgb_led_pattern_generator_unit_assert.svh.
`timescale 1ns / 1ps
`include "rgb_led_pattern_generator_unit_assert.svh"

// Usage:
// Each item on the in channel (in_valid, in_ready, in_item) is one pattern tick
// with a mode and the current millisecond time. Each item gives exactly one
// item on the out channel (out_valid, out_ready, out_item) with the three LED
// line levels after that tick.
// The cfg channel (cfg_valid, cfg_ready, cfg_data) writes the step interval in
// milliseconds; cfg_ready is always high and the write takes effect at once.
// An accepted item is held in the input register, then the pattern logic
// loads its result into the result register. Throughput is one item per
// cycle while the receiver does not stall; the 32-bit elapsed-time compare
// and the small index updates all sit between the input and result registers.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; after that in_ready drops until the
// result is taken.
// Reset clears both registers, sets all LEDs off, the step interval to 100 ms
// and the fade period to 500.
module rgb_led_pattern_generator_unit
	import rlpg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [INTERVAL_W-1:0] cfg_data
);

	logic valid_s1;
	in_item_t item_s1;
	logic out_valid_q;
	out_item_t out_q;
	logic advance;

	logic [INTERVAL_W-1:0] interval_q;
	logic [2:0] led_q, led_nxt;
	logic [TIME_W-1:0] last_q, last_nxt;
	logic [2:0] six_idx_q, six_idx_nxt;
	logic [1:0] three_idx_q, three_idx_nxt;
	logic toggle_q, toggle_nxt;
	logic fade_down_q, fade_down_nxt;
	logic [FADE_W-1:0] fade_period_q, fade_period_nxt;

	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] period;
	logic due;
	logic [3:0] colour;

	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		fade_period_nxt = fade_period_q;
		fade_down_nxt = fade_down_q;
		if (fade_down_q) begin
			if (fade_period_q != '0) begin
				fade_period_nxt = fade_period_q - 1'b1;
			end else begin
				fade_down_nxt = 1'b0;
			end
		end else begin
			if (fade_period_q < FADE_W'(FADE_LIMIT)) begin
				fade_period_nxt = fade_period_q + 1'b1;
			end else begin
				fade_down_nxt = 1'b1;
			end
		end
		if (item_s1.mode != MODE_FADE) begin
			fade_period_nxt = fade_period_q;
			fade_down_nxt = fade_down_q;
		end
	end

	always_comb begin
		elapsed = item_s1.now_ms - last_q;
		if (item_s1.mode == MODE_FADE) begin
			period = TIME_W'(fade_period_nxt);
		end else begin
			period = TIME_W'(interval_q);
		end
		due = elapsed >= period;
	end

	always_comb begin
		led_nxt = led_q;
		last_nxt = last_q;
		six_idx_nxt = six_idx_q;
		three_idx_nxt = three_idx_q;
		toggle_nxt = toggle_q;
		colour = C_KEEP;
		case (item_s1.mode)
			MODE_RED, MODE_GREEN, MODE_BLUE, MODE_CYAN, MODE_MAGENTA, MODE_YELLOW,
			MODE_WHITE: begin
				colour = static_colour(item_s1.mode[2:0]);
			end
			MODE_FADE, MODE_RAINBOW: begin
				if (due) begin
					last_nxt = item_s1.now_ms;
					if (item_s1.mode == MODE_FADE) begin
						colour = fade_colour(six_idx_q);
					end else begin
						colour = rainbow_colour(six_idx_q);
					end
					six_idx_nxt = (six_idx_q >= 3'd5) ? 3'd0 : six_idx_q + 3'd1;
				end
			end
			MODE_HOLD: begin
				colour = C_KEEP;
			end
			MODE_STROBE: begin
				if (due) begin
					last_nxt = item_s1.now_ms;
					colour = three_colour(three_idx_q);
					three_idx_nxt = (three_idx_q >= 2'd2) ? 2'd0 : three_idx_q + 2'd1;
				end
			end
			MODE_RED_BLUE, MODE_GREEN_RED, MODE_BLUE_GREEN: begin
				if (due) begin
					last_nxt = item_s1.now_ms;
					toggle_nxt = !toggle_q;
					if (item_s1.mode == MODE_RED_BLUE) begin
						colour = toggle_q ? C_BLUE : C_RED;
					end else if (item_s1.mode == MODE_GREEN_RED) begin
						colour = toggle_q ? C_RED : C_GREEN;
					end else begin
						colour = toggle_q ? C_GREEN : C_BLUE;
					end
				end
			end
			MODE_OFF_A, MODE_OFF_B: begin
				colour = C_OFF;
			end
			default: begin
				colour = C_KEEP;
			end
		endcase
		if (colour != C_KEEP) begin
			led_nxt = colour[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.red_on <= led_nxt[0];
			out_q.green_on <= led_nxt[1];
			out_q.blue_on <= led_nxt[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q <= 3'b000;
			last_q <= '0;
			six_idx_q <= '0;
			three_idx_q <= '0;
			toggle_q <= 1'b0;
			fade_down_q <= 1'b0;
			fade_period_q <= FADE_PERIOD_RESET;
		end else if (advance && valid_s1) begin
			led_q <= led_nxt;
			last_q <= last_nxt;
			six_idx_q <= six_idx_nxt;
			three_idx_q <= three_idx_nxt;
			toggle_q <= toggle_nxt;
			fade_down_q <= fade_down_nxt;
			fade_period_q <= fade_period_nxt;
		end
	end

	`RLPG_ASSERT_NOW(a_six_idx_range, 1'b1, six_idx_q <= 3'd5, "six-color index out of range")
	`RLPG_ASSERT_NOW(a_three_idx_range, 1'b1, three_idx_q <= 2'd2, "three-color index out of range")
	`RLPG_ASSERT_NOW(a_fade_range, 1'b1, fade_period_q <= FADE_W'(FADE_LIMIT), "fade period above limit")
	`RLPG_ASSERT_NOW(a_full_stall, valid_s1 && out_valid_q && !out_ready, !in_ready, "accepted while full")
	`RLPG_ASSERT_NEXT(a_hold_keeps, advance && valid_s1 && item_s1.mode == MODE_HOLD, $stable(led_q) && $stable(last_q), "hold item changed state")

endmodule

// File: bench/tb_rgb_led_pattern_generator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_led_pattern_generator_unit: directed and random
// pattern ticks under random stalls, with a built-in model of the LED state.
// Depends on rlpg_pkg and the RTL of the block.

module tb_rgb_led_pattern_generator_unit;
	import rlpg_pkg::*;

	// Color sequences, three bits per entry (red bit 0), first entry lowest.
	localparam logic [20:0] STATIC_ORDER = {C_WHITE[2:0], C_YELLOW[2:0], C_MAGENTA[2:0],
		C_CYAN[2:0], C_BLUE[2:0], C_GREEN[2:0], C_RED[2:0]};
	localparam logic [17:0] FADE_ORDER = {C_MAGENTA[2:0], C_BLUE[2:0], C_CYAN[2:0],
		C_GREEN[2:0], C_YELLOW[2:0], C_RED[2:0]};
	localparam logic [17:0] RAINBOW_ORDER = {C_MAGENTA[2:0], C_YELLOW[2:0], C_CYAN[2:0],
		C_BLUE[2:0], C_GREEN[2:0], C_RED[2:0]};
	localparam logic [8:0] STROBE_ORDER = {C_BLUE[2:0], C_GREEN[2:0], C_RED[2:0]};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [INTERVAL_W-1:0] cfg_data;

	logic [2:0] led_model;
	logic [TIME_W-1:0] last_step_ms;
	logic [2:0] six_index;
	logic [1:0] three_index;
	logic toggle_second;
	logic fade_falling;
	logic [FADE_W-1:0] fade_period_ms;
	logic [INTERVAL_W-1:0] interval_ms;

	out_item_t expected_leds[$];
	int error_count = 0;
	int stall_left = 0;
	bit quiet_in;
	bit quiet_out;
	logic [TIME_W-1:0] clock_ms;

	rgb_led_pattern_generator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap(input bit quiet);
		if (quiet || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic void predict_tick(input in_item_t item);
		logic [TIME_W-1:0] elapsed;
		elapsed = item.now_ms - last_step_ms;
		case (item.mode)
			MODE_RED, MODE_GREEN, MODE_BLUE, MODE_CYAN, MODE_MAGENTA, MODE_YELLOW,
			MODE_WHITE:
				led_model = STATIC_ORDER[item.mode[2:0] * 3 +: 3];
			MODE_FADE: begin
				if (fade_falling) begin
					if (fade_period_ms != '0)
						fade_period_ms = fade_period_ms - 1'b1;
					else
						fade_falling = 1'b0;
				end else if (fade_period_ms < FADE_LIMIT) begin
					fade_period_ms = fade_period_ms + 1'b1;
				end else begin
					fade_falling = 1'b1;
				end
				if (elapsed >= fade_period_ms) begin
					last_step_ms = item.now_ms;
					if (six_index <= 3'd5)
						led_model = FADE_ORDER[six_index * 3 +: 3];
					six_index = (six_index >= 3'd5) ? 3'd0 : six_index + 3'd1;
				end
			end
			MODE_HOLD: ;
			MODE_STROBE, MODE_RAINBOW, MODE_RED_BLUE, MODE_GREEN_RED, MODE_BLUE_GREEN: begin
				if (elapsed >= interval_ms) begin
					last_step_ms = item.now_ms;
					case (item.mode)
						MODE_STROBE: begin
							if (three_index <= 2'd2)
								led_model = STROBE_ORDER[three_index * 3 +: 3];
							three_index = (three_index >= 2'd2) ? 2'd0 : three_index + 2'd1;
						end
						MODE_RAINBOW: begin
							if (six_index <= 3'd5)
								led_model = RAINBOW_ORDER[six_index * 3 +: 3];
							six_index = (six_index >= 3'd5) ? 3'd0 : six_index + 3'd1;
						end
						MODE_RED_BLUE:
							led_model = toggle_second ? C_BLUE[2:0] : C_RED[2:0];
						MODE_GREEN_RED:
							led_model = toggle_second ? C_RED[2:0] : C_GREEN[2:0];
						default:
							led_model = toggle_second ? C_GREEN[2:0] : C_BLUE[2:0];
					endcase
					if (item.mode >= MODE_RED_BLUE)
						toggle_second = ~toggle_second;
				end
			end
			default:
				led_model = C_OFF[2:0];
		endcase
		expected_leds.push_back('{red_on: led_model[0], green_on: led_model[1],
			blue_on: led_model[2]});
	endfunction

	task automatic send_tick(input logic [3:0] mode, input logic [TIME_W-1:0] now_ms);
		int gap;
		gap = draw_gap(quiet_in);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{mode: mode, now_ms: now_ms};
		do @(posedge clk); while (!in_ready);
		predict_tick('{mode: mode, now_ms: now_ms});
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (expected_leds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_interval(input logic [INTERVAL_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		interval_ms = value;
	endtask

	task automatic report_field(input string field, input logic want, input logic got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s expected %b actual %b", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			if (expected_leds.size() == 0) begin
				error_count++;
				$display("%0t: result item expected none actual %b", $time, out_item);
			end else begin
				want = expected_leds.pop_front();
				report_field("red_on", want.red_on, out_item.red_on);
				report_field("green_on", want.green_on, out_item.green_on);
				report_field("blue_on", want.blue_on, out_item.blue_on);
			end
			stall_left = draw_gap(quiet_out);
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic test_reset_state();
		send_tick(MODE_STROBE, 32'd99);
		send_tick(MODE_HOLD, 32'hFFFF_FFFF);
		send_tick(MODE_FADE, 32'd500);
		send_tick(MODE_FADE, 32'd502);
	endtask

	task automatic test_static_colors();
		for (int m = MODE_RED; m <= MODE_WHITE; m++)
			send_tick(4'(m), $urandom);
		send_tick(MODE_HOLD, $urandom);
		send_tick(MODE_OFF_A, $urandom);
		send_tick(MODE_WHITE, $urandom);
		send_tick(MODE_OFF_B, $urandom);
	endtask

	task automatic test_timed_patterns();
		logic [TIME_W-1:0] t;
		t = last_step_ms;
		send_tick(MODE_STROBE, t + 32'd100);
		send_tick(MODE_STROBE, t + 32'd200);
		send_tick(MODE_STROBE, t + 32'd300);
		send_tick(MODE_RAINBOW, t + 32'd400);
		send_tick(MODE_RAINBOW, t + 32'd499);
		send_tick(MODE_RAINBOW, t + 32'd500);
		send_tick(MODE_RED_BLUE, t + 32'd600);
		send_tick(MODE_GREEN_RED, t + 32'd700);
		send_tick(MODE_BLUE_GREEN, t + 32'd800);
		send_tick(MODE_RED_BLUE, t + 32'd900);
	endtask

	task automatic test_time_wrap();
		send_tick(MODE_STROBE, 32'hFFFF_FFC0);
		send_tick(MODE_STROBE, 32'h0000_0023);
		send_tick(MODE_STROBE, 32'h0000_0024);
	endtask

	task automatic test_fade_ramp();
		wait_results_done();
		quiet_in = 1'b1;
		quiet_out = 1'($urandom_range(0, 1));
		clock_ms = last_step_ms;
		for (int n = 0; n < 130; n++) begin
			clock_ms = clock_ms + $urandom_range(0, 400);
			send_tick(MODE_FADE, clock_ms);
		end
		for (int n = 0; n < 20; n++) begin
			clock_ms = clock_ms + $urandom_range(0, 3);
			send_tick(MODE_FADE, clock_ms);
		end
	endtask

	task automatic send_random_tick();
		logic [3:0] mode;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			mode = 4'($urandom_range(MODE_FADE, MODE_BLUE_GREEN));
			clock_ms = clock_ms + $urandom_range(0, 2 * interval_ms + 2);
		end else if (pick < 83) begin
			mode = 4'($urandom);
			clock_ms = clock_ms + $urandom_range(0, 50);
		end else if (pick < 92) begin
			mode = 4'($urandom_range(MODE_FADE, MODE_BLUE_GREEN));
			clock_ms = last_step_ms + interval_ms + $urandom_range(0, 1) - 1;
		end else if (pick < 96) begin
			mode = 4'($urandom);
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * interval_ms);
		end else begin
			mode = 4'($urandom);
			clock_ms = $urandom;
		end
		send_tick(mode, clock_ms);
	endtask

	task automatic test_random_patterns();
		logic [INTERVAL_W-1:0] setting;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: setting = '0;
				1: setting = '1;
				2: setting = 16'd1;
				3: setting = 16'($urandom_range(2, 300));
				default: setting = 16'($urandom);
			endcase
			wait_results_done();
			write_interval(setting);
			quiet_in = ($urandom_range(0, 3) == 0);
			quiet_out = ($urandom_range(0, 3) == 0);
			clock_ms = last_step_ms;
			for (int n = 0; n < 120; n++) begin
				if (n == 60)
					wait_results_done();
				send_random_tick();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		led_model = '0;
		last_step_ms = '0;
		six_index = '0;
		three_index = '0;
		toggle_second = 1'b0;
		fade_falling = 1'b0;
		fade_period_ms = FADE_PERIOD_RESET;
		interval_ms = INTERVAL_RESET;
		quiet_in = 1'b0;
		quiet_out = 1'b0;
		clock_ms = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_static_colors();
		test_timed_patterns();
		test_time_wrap();
		test_fade_ramp();
		test_random_patterns();
		wait_results_done();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
